// ===== hw/rtl/ema_spike_hold_filter_defines.svh =====
// Assertion helpers for the spike-hold filter.
`ifndef EMA_SPIKE_HOLD_FILTER_DEFINES_SVH
`define EMA_SPIKE_HOLD_FILTER_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define ESH_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define ESH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/esh_pkg.sv =====
package esh_pkg;

   // Register file layout
   localparam int CSR_INDEX_BITS = 1;
   localparam int GAIN_BITS      = 17;
   localparam int THRESH_BITS    = 16;
   localparam int FRAC_BITS      = 8;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SMOOTHING_GAIN  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPIKE_THRESHOLD = 1'd1;

   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 17'd16384;
   localparam logic [GAIN_BITS-1:0]   GAIN_ONE     = 17'd65536;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 16'd100;

   // Rounding offset for the Q1.16 gain product
   localparam int ROUND_HALF = 32768;
   localparam int GAIN_SHIFT = 16;

   typedef enum logic {
      CMD_FILTER  = 1'b0,
      CMD_RESTART = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0]   smoothing_gain;
      logic [THRESH_BITS-1:0] spike_threshold;
   } cfg_type;

endpackage

// ===== hw/rtl/esh_csr.sv =====
module esh_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [esh_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [esh_pkg::GAIN_BITS-1:0]        csr_wdata,
   output esh_pkg::cfg_type                     cfg
);

   esh_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; unknown indexes drop the word
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            esh_pkg::REG_SMOOTHING_GAIN:  cfg_in.smoothing_gain = csr_wdata;
            esh_pkg::REG_SPIKE_THRESHOLD:
               cfg_in.spike_threshold = csr_wdata[esh_pkg::THRESH_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothing_gain  <= esh_pkg::GAIN_RESET;
         cfg_ff.spike_threshold <= esh_pkg::THRESH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/esh_core.sv =====
module esh_core #(
   parameter int HOLD_CYCLES = 3,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  esh_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic signed [SAMPLE_BITS-1:0] res_filtered,
   output logic                          res_holding
);

   localparam int FB     = esh_pkg::FRAC_BITS;
   localparam int AW     = SAMPLE_BITS + FB;
   localparam int DW     = AW + 1;
   localparam int TQW    = esh_pkg::THRESH_BITS + FB;
   localparam int CW     = (DW > TQW) ? DW : TQW;
   localparam int PW     = AW + 19;
   localparam int HW     = $clog2(HOLD_CYCLES + 1);

   // Input register
   logic                          in_valid_ff, in_valid_in;
   esh_pkg::cmd_type              cmd_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;

   // Filter state
   logic                          seeded_ff, seeded_in;
   logic [HW-1:0]                 hold_ff, hold_in;
   logic signed [AW-1:0]          avg_ff, avg_in;

   logic                          consume;
   logic signed [AW-1:0]          xq;
   logic signed [DW-1:0]          diff;
   logic [DW-1:0]                 mag;
   logic                          in_band;
   logic [esh_pkg::GAIN_BITS-1:0] gain_sat;
   logic signed [PW-1:0]          prod;
   logic signed [PW-1:0]          rnd;
   logic signed [AW-1:0]          ema;

   // A restart retires without a result slot
   assign consume   = in_valid_ff && (cmd_ff == esh_pkg::CMD_RESTART || res_ready);
   assign req_ready = !in_valid_ff || consume;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff    <= esh_pkg::cmd_type'(req_command);
         sample_ff <= req_sample;
      end
   end

   // Distance from the last output and the spike test
   assign xq   = {sample_ff, {FB{1'b0}}};
   assign diff = DW'(xq) - DW'(avg_ff);
   assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
   assign in_band = CW'(mag) < CW'({cfg.spike_threshold, {FB{1'b0}}});

   // Average step: gain * difference, round half up, drop 16 fraction bits
   assign gain_sat = (cfg.smoothing_gain > esh_pkg::GAIN_ONE) ? esh_pkg::GAIN_ONE
                                                               : cfg.smoothing_gain;
   assign prod = $signed({1'b0, gain_sat}) * diff;
   assign rnd  = prod + PW'(esh_pkg::ROUND_HALF);
   assign ema  = avg_ff + AW'(rnd >>> esh_pkg::GAIN_SHIFT);

   // Next state
   always_comb begin
      seeded_in = seeded_ff;
      hold_in   = hold_ff;
      avg_in    = avg_ff;
      if (consume) begin
         if (cmd_ff == esh_pkg::CMD_RESTART) begin
            seeded_in = 1'b0;
            hold_in   = '0;
         end else if (!seeded_ff) begin
            avg_in    = xq;
            seeded_in = 1'b1;
         end else if (hold_ff != '0) begin
            hold_in = hold_ff - HW'(1);
            if (in_band) begin
               avg_in  = ema;
               hold_in = '0;
            end else if (hold_ff == HW'(1)) begin
               // spike outlasted the window: adopt it
               avg_in = xq;
            end
         end else if (in_band) begin
            avg_in = ema;
         end else begin
            hold_in = HW'(HOLD_CYCLES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
         hold_ff   <= '0;
      end else begin
         seeded_ff <= seeded_in;
         hold_ff   <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
   end

   // Result word
   assign res_valid    = in_valid_ff && cmd_ff == esh_pkg::CMD_FILTER;
   assign res_filtered = avg_in[AW-1:FB];
   assign res_holding  = hold_in != '0;

endmodule

// ===== hw/rtl/esh_out.sv =====
module esh_out #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   output logic                          res_ready,
   input  logic signed [SAMPLE_BITS-1:0] res_filtered,
   input  logic                          res_holding,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   output logic                          rsp_holding
);

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] filtered_ff;
   logic                          holding_ff;
   logic                          load;

   // Take a new word whenever the slot is empty or being drained
   assign res_ready = !valid_ff || rsp_ready;
   assign load      = res_valid && res_ready;
   assign valid_in  = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         filtered_ff <= res_filtered;
         holding_ff  <= res_holding;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_filtered = filtered_ff;
   assign rsp_holding  = holding_ff;

endmodule

// ===== hw/rtl/ema_spike_hold_filter.sv =====
// Channel   Ports                                  Direction  Moves
// req       req_valid/ready, command, sample       in         one sample or restart word
// rsp       rsp_valid/ready, filtered, holding     out        one filtered word
// csr       csr_valid/ready, index, wdata          in         one register write
//
// Throughput: one word per cycle while rsp is not stalled; a result is valid on rsp
// once its req word has passed the input register, then the result register. The
// limit is the loop through the average register (a subtract, a negate, a compare,
// a multiply and two adds). Restart words leave no result.
// Reset is synchronous, active high; it clears valid flags, seed and hold state
// and loads register defaults. A stalled rsp fills the result slot, then the
// input register, then drops req_ready.
`include "ema_spike_hold_filter_defines.svh"

module ema_spike_hold_filter #(
   parameter int HOLD_CYCLES = 3,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_filtered,
   output logic                               rsp_holding,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [esh_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [esh_pkg::GAIN_BITS-1:0]      csr_wdata
);

   esh_pkg::cfg_type              cfg;
   logic                          res_valid;
   logic                          res_ready;
   logic signed [SAMPLE_BITS-1:0] res_filtered;
   logic                          res_holding;

   esh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   esh_core #(
      .HOLD_CYCLES (HOLD_CYCLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_sample   (req_sample),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_filtered (res_filtered),
      .res_holding  (res_holding)
   );

   esh_out #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_out (
      .clock        (clock),
      .reset        (reset),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_filtered (res_filtered),
      .res_holding  (res_holding),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .rsp_holding  (rsp_holding)
   );

   // A filter word blocked at the result slot must stall the input side
   `ESH_ASSERT_SAME(a_stall_backs_up, res_valid && !res_ready, !req_ready, "req taken while result blocked")

   // A gain write lands in the register file on the next cycle
   `ESH_ASSERT_NEXT(a_gain_write, csr_valid && csr_ready && csr_index == esh_pkg::REG_SMOOTHING_GAIN, cfg.smoothing_gain == $past(csr_wdata), "gain write lost")

   // A full result slot that is not drained keeps the input side stalled
   `ESH_ASSERT_NEXT(a_full_slot, rsp_valid && !rsp_ready && res_valid, rsp_valid && (rsp_ready || !req_ready), "result slot drained without handshake")

endmodule

// ===== sim/tb_ema_spike_hold_filter.sv =====
module tb_ema_spike_hold_filter;

   localparam int SAMPLE_W      = 16;
   localparam int GAIN_W        = esh_pkg::GAIN_BITS;
   localparam int THRESH_W      = esh_pkg::THRESH_BITS;
   localparam int INDEX_W       = esh_pkg::CSR_INDEX_BITS;
   localparam int HOLD_SPAN     = 3;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 120;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 13;

   typedef struct {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       holding;
   } filt_word_type;

   // Filter state mirror plus the queue of filtered words still owed by the block
   class ema_scoreboard;
      logic [GAIN_W-1:0]   gain;
      logic [THRESH_W-1:0] thresh;
      bit                  seeded;
      int                  hold_left;
      longint              average;
      longint              held;
      filt_word_type       owed_q[$];
      int unsigned         errors;
      int unsigned         checked;
      int unsigned         held_seen;
      int unsigned         adoptions;
      int unsigned         restarts;

      function new();
         gain      = esh_pkg::GAIN_RESET;
         thresh    = esh_pkg::THRESH_RESET;
         seeded    = 1'b0;
         hold_left = 0;
         average   = 0;
         held      = 0;
         errors    = 0;
         checked   = 0;
         held_seen = 0;
         adoptions = 0;
         restarts  = 0;
      endfunction

      function void write_reg(logic [INDEX_W-1:0] idx, logic [GAIN_W-1:0] data);
         if (idx == esh_pkg::REG_SMOOTHING_GAIN)
            gain = data;
         else if (idx == esh_pkg::REG_SPIKE_THRESHOLD)
            thresh = data[THRESH_W-1:0];
      endfunction

      // Move the average toward the sample, gain clipped at one, round half up
      function void blend(longint xq);
         longint g;
         longint prod;
         if (gain > esh_pkg::GAIN_ONE)
            g = esh_pkg::GAIN_ONE;
         else
            g = gain;
         prod    = g * (xq - average);
         average = average + ((prod + esh_pkg::ROUND_HALF) >>> esh_pkg::GAIN_SHIFT);
         held    = average;
      endfunction

      function void note_word(esh_pkg::cmd_type cmd, logic signed [SAMPLE_W-1:0] s);
         longint        xq;
         longint        dev;
         longint        lim;
         bit            settled;
         filt_word_type w;
         if (cmd == esh_pkg::CMD_RESTART) begin
            seeded    = 1'b0;
            hold_left = 0;
            restarts++;
            return;
         end
         xq = s;
         xq = xq * 256;
         if (!seeded) begin
            average = xq;
            held    = xq;
            seeded  = 1'b1;
         end else begin
            dev = xq - held;
            if (dev < 0)
               dev = -dev;
            lim     = thresh;
            lim     = lim * 256;
            settled = dev < lim;
            if (hold_left > 0) begin
               hold_left--;
               if (settled) begin
                  blend(xq);
                  hold_left = 0;
               end else if (hold_left == 0) begin
                  // spike outlasted the window: take it as the new level
                  average = xq;
                  held    = xq;
                  adoptions++;
               end
            end else if (settled) begin
               blend(xq);
            end else begin
               hold_left = HOLD_SPAN;
            end
         end
         w.filtered = SAMPLE_W'(held >>> esh_pkg::FRAC_BITS);
         w.holding  = (hold_left != 0);
         owed_q.push_back(w);
      endfunction

      function void check_word(logic signed [SAMPLE_W-1:0] f, logic h);
         filt_word_type w;
         if (owed_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected word filtered=%0d holding=%0b", $time, f, h);
            return;
         end
         w = owed_q.pop_front();
         checked++;
         if (h === 1'b1)
            held_seen++;
         if (f !== w.filtered) begin
            errors++;
            $display("%0t: filtered expected %0d actual %0d", $time, w.filtered, f);
         end
         if (h !== w.holding) begin
            errors++;
            $display("%0t: holding expected %0b actual %0b", $time, w.holding, h);
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_command = 1'b0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic                       rsp_holding;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [INDEX_W-1:0]         csr_index = '0;
   logic [GAIN_W-1:0]          csr_wdata = '0;

   ema_scoreboard book = new();

   int          cycles = 0;
   int          burst_left = 0;
   bit          steady = 1'b0;
   bit          hold_off = 1'b0;
   int unsigned long_holds = 0;
   int unsigned words_sent = 0;
   int          cur_thr = esh_pkg::THRESH_RESET;
   int          level = 0;
   int          spike_left = 0;
   logic signed [SAMPLE_W-1:0] spike_val = '0;

   ema_spike_hold_filter #(
      .HOLD_CYCLES (HOLD_SPAN),
      .SAMPLE_BITS (SAMPLE_W)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .rsp_holding  (rsp_holding),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Track every handshake in one place: register writes, input words, results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            book.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            book.note_word(esh_pkg::cmd_type'(req_command), req_sample);
         if (rsp_valid && rsp_ready)
            book.check_word(rsp_filtered, rsp_holding);
      end
   end

   // Stall the result side in stretches of varying density; honor long hold-off requests
   initial begin : receiver
      int mode;
      int span;
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off = 1'b0;
            long_holds++;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 0);
               2: rsp_ready <= ($urandom_range(0, 9) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // Offer one word, opening a new burst after a random gap when the last one ran out
   task automatic send_word(input esh_pkg::cmd_type cmd,
                            input logic signed [SAMPLE_W-1:0] s);
      int gap;
      if (burst_left == 0) begin
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_sample  <= s;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // Hold the input until every owed word is back, then let a trailing restart clear
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.owed_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [GAIN_W-1:0] gain, input logic [GAIN_W-1:0] thr);
      csr_valid <= 1'b1;
      csr_index <= esh_pkg::REG_SMOOTHING_GAIN;
      csr_wdata <= gain;
      do @(posedge clock); while (!csr_ready);
      csr_index <= esh_pkg::REG_SPIKE_THRESHOLD;
      csr_wdata <= thr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_thr = thr[THRESH_W-1:0];
   endtask

   // Mostly a drifting level with bounded steps, plus spikes of random length,
   // fully random samples and restarts
   task automatic next_word(output esh_pkg::cmd_type cmd,
                            output logic signed [SAMPLE_W-1:0] s);
      int r;
      int span;
      int step;
      cmd = esh_pkg::CMD_FILTER;
      r   = $urandom_range(0, 99);
      if (spike_left > 0) begin
         spike_left--;
         s = spike_val;
         if (spike_left == 0 && $urandom_range(0, 1) == 0)
            level = spike_val;
      end else if (r < 3) begin
         cmd = esh_pkg::CMD_RESTART;
         s   = SAMPLE_W'($urandom_range(0, 65535));
      end else if (r < 9) begin
         spike_val  = SAMPLE_W'($urandom_range(0, 65535));
         spike_left = $urandom_range(0, 4);
         s          = spike_val;
      end else if (r < 13) begin
         s = SAMPLE_W'($urandom_range(0, 65535));
      end else begin
         span  = (cur_thr == 0) ? 50 : ((cur_thr > 2000) ? 1000 : cur_thr / 2 + 1);
         step  = $urandom_range(0, 2 * span);
         level = level + step - span;
         if (level > 32767)
            level = 32767;
         if (level < -32768)
            level = -32768;
         s = SAMPLE_W'(level);
      end
   endtask

   task automatic run_random(input int count);
      esh_pkg::cmd_type           c;
      logic signed [SAMPLE_W-1:0] s;
      int                         n;
      n = 0;
      while (n < count || hold_off) begin
         next_word(c, s);
         send_word(c, s);
         n++;
      end
   endtask

   initial begin : stimulus
      logic [GAIN_W-1:0] g;
      logic [GAIN_W-1:0] t;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: seed, settle, spike adopted after the window, settled resume
      send_word(esh_pkg::CMD_FILTER, 16'sd0);
      send_word(esh_pkg::CMD_FILTER, 16'sd99);
      send_word(esh_pkg::CMD_FILTER, -16'sd32768);
      send_word(esh_pkg::CMD_FILTER, -16'sd32768);
      send_word(esh_pkg::CMD_FILTER, -16'sd32768);
      send_word(esh_pkg::CMD_FILTER, -16'sd32768);
      send_word(esh_pkg::CMD_FILTER, 16'sd32767);
      send_word(esh_pkg::CMD_FILTER, -16'sd32700);
      send_word(esh_pkg::CMD_RESTART, 16'sh5a5a);
      send_word(esh_pkg::CMD_FILTER, 16'sd32767);
      send_word(esh_pkg::CMD_FILTER, -16'sd1);
      send_word(esh_pkg::CMD_FILTER, -16'sd1);
      send_word(esh_pkg::CMD_RESTART, -16'sd1);
      send_word(esh_pkg::CMD_RESTART, 16'sd0);
      send_word(esh_pkg::CMD_FILTER, 16'sh5555);
      send_word(esh_pkg::CMD_FILTER, 16'shaaaa);
      send_word(esh_pkg::CMD_FILTER, 16'sh5500);

      // Full gain, widest threshold: only the full-scale swing is a spike
      drain_results();
      write_config(esh_pkg::GAIN_ONE, 17'd65535);
      send_word(esh_pkg::CMD_RESTART, 16'sh1234);
      send_word(esh_pkg::CMD_FILTER, -16'sd32768);
      send_word(esh_pkg::CMD_FILTER, 16'sd32767);
      send_word(esh_pkg::CMD_FILTER, 16'sd32767);
      send_word(esh_pkg::CMD_FILTER, 16'sd32767);
      send_word(esh_pkg::CMD_FILTER, 16'sd32767);
      send_word(esh_pkg::CMD_FILTER, -16'sd32767);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         case (p)
            0: write_config('0, 17'd1000);
            1: write_config('1, 17'h10000);
            2: write_config(17'd1, 17'd1);
            default: begin
               g = ($urandom_range(0, 3) == 0) ? GAIN_W'($urandom_range(65536, 131071))
                                                : GAIN_W'($urandom_range(0, 65536));
               t = ($urandom_range(0, 7) == 0) ? GAIN_W'($urandom_range(0, 65535))
                                                : GAIN_W'($urandom_range(1, 3000));
               t[GAIN_W-1] = 1'($urandom_range(0, 1));
               write_config(g, t);
            end
         endcase
         if (p == 5) begin
            hold_off = 1'b1;
            steady   = 1'b1;
         end
         run_random((p < 3) ? 100 : 112);
         steady = 1'b0;
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("Sent %0d words (%0d restarts) across %0d register settings; checked %0d results.",
               words_sent, book.restarts, PHASES + 2, book.checked);
      $display("Held results: %0d, spikes adopted: %0d, long receiver hold-offs: %0d.",
               book.held_seen, book.adoptions, long_holds);
      if (book.errors == 0 && book.owed_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
